// ----- rtl/core/ptd_pkg.sv -----
package ptd_pkg;

   // default width of the tested number
   localparam int NUMBER_BITS_DEF = 31;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/core/ptd_divider.sv -----
module ptd_divider #(
   parameter int NUMBER_BITS = ptd_pkg::NUMBER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUMBER_BITS-1:0] dividend,
   input  logic [NUMBER_BITS-1:0] divisor,
   output logic                   done,
   output logic [NUMBER_BITS-1:0] quotient,
   output logic [NUMBER_BITS-1:0] remainder
);

   localparam int CntBits = $clog2(NUMBER_BITS + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CntBits-1:0]     cnt_ff, cnt_in;
   logic [NUMBER_BITS-1:0] quo_ff, quo_in;
   logic [NUMBER_BITS-1:0] rem_ff, rem_in;
   logic [NUMBER_BITS-1:0] dvs_ff, dvs_in;
   logic [NUMBER_BITS:0]   trial;
   logic [NUMBER_BITS:0]   diff;
   logic                   fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[NUMBER_BITS-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntBits'(NUMBER_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUMBER_BITS-2:0], fits};
         rem_in = fits ? diff[NUMBER_BITS-1:0] : trial[NUMBER_BITS-1:0];
         cnt_in = cnt_ff - CntBits'(1);
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/core/trial_division_prime_test_top.sv -----
// channel  | direction | ports                         | payload
// ---------+-----------+-------------------------------+---------------------------
// request  | in        | req_valid, req_stall          | req_number [NUMBER_BITS]
// response | out       | rsp_valid, rsp_stall          | rsp_is_prime [1]
//
// one item at a time: odd numbers of 5 and up run odd trial divisors 3, 5, 7 and so on
// through one shared restoring divider until divisor > quotient or a zero remainder.
// numbers below 5 and even numbers skip the divider.
// reset is synchronous and clears control only; a stalled response holds in its
// register while the next item is already taken in.
module trial_division_prime_test_top #(
   parameter int NUMBER_BITS = ptd_pkg::NUMBER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [NUMBER_BITS-1:0] req_number,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_is_prime
);

   ptd_pkg::state_type state_ff, state_in;

   logic [NUMBER_BITS-1:0] num_ff, num_in;
   logic [NUMBER_BITS-1:0] dvs_ff, dvs_in;
   logic                   res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_is_prime_ff, rsp_is_prime_in;

   logic                   div_start;
   logic                   div_done;
   logic [NUMBER_BITS-1:0] div_quo;
   logic [NUMBER_BITS-1:0] div_rem;

   logic                   small_case;
   logic                   past_bound;
   logic                   hit;
   logic                   out_free;
   logic                   out_load;

   always_comb begin
      small_case = (num_ff < NUMBER_BITS'(4)) || !num_ff[0];
      past_bound = (dvs_ff > div_quo);
      hit        = (div_rem == '0);
      out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptd_pkg::ST_IDLE: begin
            if (req_valid) state_in = ptd_pkg::ST_CHECK;
         end
         ptd_pkg::ST_CHECK: begin
            state_in = small_case ? ptd_pkg::ST_FINISH : ptd_pkg::ST_DIVIDE;
         end
         ptd_pkg::ST_DIVIDE: begin
            if (div_done && (past_bound || hit)) state_in = ptd_pkg::ST_FINISH;
         end
         ptd_pkg::ST_FINISH: begin
            if (out_free) state_in = ptd_pkg::ST_IDLE;
         end
         default: state_in = ptd_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      out_load  = 1'b0;
      num_in    = num_ff;
      dvs_in    = dvs_ff;
      res_in    = res_ff;
      case (state_ff)
         ptd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            num_in    = req_number;
         end
         ptd_pkg::ST_CHECK: begin
            if (small_case) begin
               // 2 and 3 are prime, 0, 1 and other even numbers are not
               res_in = (num_ff >= NUMBER_BITS'(2)) && (num_ff < NUMBER_BITS'(4));
            end else begin
               dvs_in    = NUMBER_BITS'(3);
               div_start = 1'b1;
            end
         end
         ptd_pkg::ST_DIVIDE: begin
            if (div_done) begin
               if (past_bound) begin
                  res_in = 1'b1;
               end else if (hit) begin
                  res_in = 1'b0;
               end else begin
                  dvs_in    = dvs_ff + NUMBER_BITS'(2);
                  div_start = 1'b1;
               end
            end
         end
         ptd_pkg::ST_FINISH: begin
            out_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_is_prime_in = rsp_is_prime_ff;
      if (out_load) begin
         rsp_valid_in    = 1'b1;
         rsp_is_prime_in = res_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_ff          <= num_in;
      dvs_ff          <= dvs_in;
      res_ff          <= res_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   ptd_divider #(
      .NUMBER_BITS(NUMBER_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (num_ff),
      .divisor   (dvs_in),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

endmodule

// ----- dv/prime_test_checker.sv -----
`timescale 1ns / 1ps

module prime_test_checker #(
   parameter int NUMBER_BITS = ptd_pkg::NUMBER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [NUMBER_BITS-1:0] req_number,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_is_prime,
   output int                     mismatches,
   output int                     outstanding
);

   bit prime_flags_due[$];
   int errors_seen = 0;

   // odd divisors from 3 while d*d <= n, bound written as d <= n/d
   function automatic bit is_prime_number(input logic [NUMBER_BITS-1:0] n);
      longint unsigned value;
      longint unsigned d;
      value = longint'(n);
      if (value < 2) return 1'b0;
      if (value < 4) return 1'b1;
      if (value % 2 == 0) return 1'b0;
      for (d = 3; d <= value / d; d += 2) begin
         if (value % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      bit want;
      if (!reset) begin
         // retire the result first so a result cannot match the item taken at this edge
         if (rsp_valid && !rsp_stall) begin
            if (prime_flags_due.size() == 0) begin
               $error("is_prime: result %0b with no item outstanding", rsp_is_prime);
               errors_seen++;
            end else begin
               want = prime_flags_due.pop_front();
               if (rsp_is_prime !== want) begin
                  $error("is_prime: expected %0b, actual %0b", want, rsp_is_prime);
                  errors_seen++;
               end
            end
         end
         if (req_valid && !req_stall)
            prime_flags_due.push_back(is_prime_number(req_number));
      end
      mismatches <= errors_seen;
      outstanding <= prime_flags_due.size();
   end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int NB = ptd_pkg::NUMBER_BITS_DEF;
   localparam int RANDOM_ITEMS = 77;
   localparam int unsigned CYCLE_LIMIT = 20_000_000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [NB-1:0] req_number = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_is_prime;

   int          mismatches;
   int          outstanding;
   bit          steady = 1'b0;
   int          wide_left = 3;
   int unsigned cycle_count = 0;

   always #5 clock = ~clock;

   trial_division_prime_test_top #(
      .NUMBER_BITS(NB)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_number  (req_number),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_is_prime(rsp_is_prime)
   );

   prime_test_checker #(
      .NUMBER_BITS(NB)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_number  (req_number),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_is_prime(rsp_is_prime),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 33);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[trial_division_prime_test_top] ERROR");
         $finish;
      end
   end

   // large primes take long to test, so at most three random items use the full width
   function automatic logic [NB-1:0] pick_number();
      int unsigned roll;
      int unsigned w;
      logic [31:0] raw;
      roll = $urandom_range(0, 99);
      raw = $urandom;
      if (roll < 5 && wide_left > 0) begin
         wide_left--;
         return raw[NB-1:0];
      end
      if (roll < 15) w = $urandom_range(17, 20);
      else w = $urandom_range(2, 16);
      raw = raw & ((32'd1 << w) - 32'd1);
      // lean toward odd numbers so primes turn up often
      if ($urandom_range(0, 1) == 1) raw[0] = 1'b1;
      return raw[NB-1:0];
   endfunction

   task automatic offer_number(input logic [NB-1:0] n);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_number <= n;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      int unsigned directed_numbers[$];
      directed_numbers = '{
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 15, 25, 49, 97, 121,
         63001, 65521, 65535, 1073741824, 1431655765, 715827882,
         2147483646, 2147483647
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_numbers[i]) offer_number(NB'(directed_numbers[i]));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // a stretch with neither side idling
         steady <= (i >= 40 && i < 70);
         offer_number(pick_number());
      end
      steady <= 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0) begin
         $display("[trial_division_prime_test_top] OK");
      end else begin
         $display("[trial_division_prime_test_top] ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/ptd_pkg.sv
rtl/core/ptd_divider.sv
rtl/core/trial_division_prime_test_top.sv
dv/prime_test_checker.sv
dv/testbench.sv
